// ----- sv/olpm_pkg.sv -----
// ----------------------------------------------------------------------------
// olpm_pkg
// Shared types and constants for the ordered list with position map.
// ----------------------------------------------------------------------------
package olpm_pkg;

    localparam int MAX_ITEMS = 64;
    localparam int ID_SPACE  = 64;
    localparam int ID_W      = 6;
    localparam int POS_W     = 6;
    localparam int CNT_W     = 7;

    typedef logic [ID_W-1:0]  t_id;
    typedef logic [POS_W-1:0] t_pos;
    typedef logic [CNT_W-1:0] t_cnt;

    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_REMOVE = 2'd1,
        OP_SWAP   = 2'd2,
        OP_GET    = 2'd3
    } t_op;

    typedef struct packed {
        t_op  op;
        t_id  arg_a;
        t_id  arg_b;
    } t_in_item;

    typedef struct packed {
        t_pos position;
        logic found;
        logic error;
        t_cnt count;
        logic emptied;
    } t_out_item;

endpackage

// ----- sv/ordered_list_with_position_map_unit.sv -----
// ----------------------------------------------------------------------------
// ordered_list_with_position_map_unit
// Ordered id list with a reverse id-to-position map, held in two memories.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) carries one operation
//   item: append, remove, swap positions, or get position of an id.
//   Output channel (o_out_valid / i_out_ready / o_out_data) returns exactly
//   one result item per input item, in order.
//   One item at a time. Each item passes a lookup state; a swap then writes
//   both positions in turn, and a remove of an entry other than the last
//   shifts later entries one per cycle through the single write port of
//   the order memory. The next item is accepted in the cycle after its
//   predecessor's result loads.
//   A finished result waits in the output register while the receiver
//   stalls; the next item is accepted during that time, and its result is
//   held back until the output register frees up.
//   Reset (synchronous, active low) empties the list and marks every id as
//   not present; no clearing pass is needed, the block is ready at once.
// ----------------------------------------------------------------------------
module ordered_list_with_position_map_unit
    import olpm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_SHIFT,
        S_SWAP,
        S_SWAP2,
        S_EMIT
    } t_state;

    t_state              r_state;
    t_op                 r_op;
    t_id                 r_a;
    t_id                 r_b;
    t_pos                r_k;
    t_id                 r_ida;
    t_cnt                r_count;
    logic [ID_SPACE-1:0] r_present;
    t_out_item           r_res;
    t_out_item           n_res;
    t_out_item           r_out;
    logic                r_out_valid;

    // memories
    t_id  order_mem [MAX_ITEMS];
    t_pos map_mem   [ID_SPACE];
    t_id  r_ord_rd;
    t_pos r_map_rd;

    t_pos ord_ra;
    logic ord_we;
    t_pos ord_wa;
    t_id  ord_wd;
    t_id  map_ra;
    logic map_we;
    t_id  map_wa;
    t_pos map_wd;

    logic lk_present;
    logic full;
    logic swap_ok;
    t_cnt p_next;
    t_cnt cnt_dec;
    logic in_acc;
    logic out_load;

    assign in_acc     = i_in_valid && o_in_ready;
    assign lk_present = r_present[r_a];
    assign full       = r_count >= CNT_W'(MAX_ITEMS);
    assign swap_ok    = ({1'b0, r_a} < r_count) && ({1'b0, r_b} < r_count);
    assign p_next     = {1'b0, r_map_rd} + CNT_W'(1);
    assign cnt_dec    = r_count - CNT_W'(1);
    assign out_load   = (r_state == S_EMIT) && (!r_out_valid || i_out_ready);

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        ord_ra = r_a;
        ord_we = 1'b0;
        ord_wa = r_a;
        ord_wd = r_a;
        map_ra = r_a;
        map_we = 1'b0;
        map_wa = r_a;
        map_wd = r_count[POS_W-1:0];
        unique case (r_state)
            S_IDLE: begin
                ord_ra = i_in_data.arg_a;
                map_ra = i_in_data.arg_a;
            end
            S_LOOK: begin
                ord_ra = (r_op == OP_REMOVE) ? p_next[POS_W-1:0] : r_b;
                if (r_op == OP_APPEND && !lk_present && !full) begin
                    ord_we = 1'b1;
                    ord_wa = r_count[POS_W-1:0];
                    ord_wd = r_a;
                    map_we = 1'b1;
                    map_wa = r_a;
                    map_wd = r_count[POS_W-1:0];
                end
            end
            S_SHIFT: begin
                ord_ra = r_k + POS_W'(2);
                ord_we = 1'b1;
                ord_wa = r_k;
                ord_wd = r_ord_rd;
                map_we = 1'b1;
                map_wa = r_ord_rd;
                map_wd = r_k;
            end
            S_SWAP: begin
                ord_we = 1'b1;
                ord_wa = r_a;
                ord_wd = r_ord_rd;
                map_we = 1'b1;
                map_wa = r_ord_rd;
                map_wd = r_a;
            end
            S_SWAP2: begin
                ord_we = 1'b1;
                ord_wa = r_b;
                ord_wd = r_ida;
                map_we = 1'b1;
                map_wa = r_ida;
                map_wd = r_b;
            end
            S_EMIT: begin
            end
            default: begin
            end
        endcase
    end

    // result of the lookup cycle
    always_comb begin
        n_res = '{position: '0, found: 1'b0, error: 1'b1,
                  count: r_count, emptied: 1'b0};
        unique case (r_op)
            OP_APPEND: begin
                if (lk_present) begin
                    n_res.position = r_map_rd;
                    n_res.found    = 1'b1;
                end else if (!full) begin
                    n_res.position = r_count[POS_W-1:0];
                    n_res.error    = 1'b0;
                    n_res.count    = r_count + CNT_W'(1);
                end
            end
            OP_GET: begin
                if (lk_present) begin
                    n_res.position = r_map_rd;
                    n_res.found    = 1'b1;
                    n_res.error    = 1'b0;
                end
            end
            OP_REMOVE: begin
                if (lk_present) begin
                    n_res.position = r_map_rd;
                    n_res.found    = 1'b1;
                    n_res.error    = 1'b0;
                    n_res.count    = cnt_dec;
                    n_res.emptied  = (cnt_dec == '0);
                end
            end
            OP_SWAP: begin
                n_res.position = r_a;
                n_res.error    = !swap_ok;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (ord_we) begin
            order_mem[ord_wa] <= ord_wd;
        end
        r_ord_rd <= order_mem[ord_ra];
    end

    always_ff @(posedge i_clk) begin
        if (map_we) begin
            map_mem[map_wa] <= map_wd;
        end
        r_map_rd <= map_mem[map_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_present   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_op    <= i_in_data.op;
                        r_a     <= i_in_data.arg_a;
                        r_b     <= i_in_data.arg_b;
                        r_state <= S_LOOK;
                    end
                end
                S_LOOK: begin
                    r_res <= n_res;
                    unique case (r_op)
                        OP_APPEND: begin
                            if (!lk_present && !full) begin
                                r_present[r_a] <= 1'b1;
                                r_count        <= r_count + CNT_W'(1);
                            end
                            r_state <= S_EMIT;
                        end
                        OP_REMOVE: begin
                            if (lk_present) begin
                                r_present[r_a] <= 1'b0;
                                r_count        <= cnt_dec;
                                r_k            <= r_map_rd;
                            end
                            if (lk_present && ({1'b0, r_map_rd} < cnt_dec)) begin
                                r_state <= S_SHIFT;
                            end else begin
                                r_state <= S_EMIT;
                            end
                        end
                        OP_SWAP: begin
                            if (swap_ok) begin
                                r_ida   <= r_ord_rd;
                                r_state <= S_SWAP;
                            end else begin
                                r_state <= S_EMIT;
                            end
                        end
                        default: begin
                            r_state <= S_EMIT;
                        end
                    endcase
                end
                S_SHIFT: begin
                    // r_count already holds the decremented count
                    r_k <= r_k + POS_W'(1);
                    if (!(({1'b0, r_k} + CNT_W'(1)) < r_count)) begin
                        r_state <= S_EMIT;
                    end
                end
                S_SWAP: begin
                    r_state <= S_SWAP2;
                end
                S_SWAP2: begin
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (out_load) begin
                        r_out   <= r_res;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
